FILE: rtl/itr_pkg.sv
// shared types, constants and symbol tables for the integer to roman encoder
package itr_pkg;

    // operand range
    localparam int VALUE_W = 12;
    typedef logic [VALUE_W-1:0] value_t;
    localparam value_t MAX_VALUE = 12'd3999;

    // output character
    localparam int SYM_W = 8;
    typedef logic [SYM_W-1:0] symbol_t;

    // ascii codes of the numeral letters
    localparam symbol_t SYM_NONE = 8'h00;
    localparam symbol_t LETTER_I = 8'h49;
    localparam symbol_t LETTER_V = 8'h56;
    localparam symbol_t LETTER_X = 8'h58;
    localparam symbol_t LETTER_L = 8'h4C;
    localparam symbol_t LETTER_C = 8'h43;
    localparam symbol_t LETTER_D = 8'h44;
    localparam symbol_t LETTER_M = 8'h4D;

    // greedy subtraction table, largest step first
    localparam int TABLE_SIZE = 13;
    localparam int POS_W = 4;
    typedef logic [POS_W-1:0] pos_t;

    localparam value_t STEP_VALUE [TABLE_SIZE] = '{
        12'd1000, 12'd900, 12'd500, 12'd400, 12'd100, 12'd90, 12'd50,
        12'd40, 12'd10, 12'd9, 12'd5, 12'd4, 12'd1
    };
    localparam symbol_t FIRST_LETTER [TABLE_SIZE] = '{
        LETTER_M, LETTER_C, LETTER_D, LETTER_C, LETTER_C, LETTER_X, LETTER_L,
        LETTER_X, LETTER_X, LETTER_I, LETTER_V, LETTER_I, LETTER_I
    };
    localparam symbol_t SECOND_LETTER [TABLE_SIZE] = '{
        SYM_NONE, LETTER_M, SYM_NONE, LETTER_D, SYM_NONE, LETTER_C, SYM_NONE,
        LETTER_L, SYM_NONE, LETTER_X, SYM_NONE, LETTER_V, SYM_NONE
    };

    // classification of an accepted item
    typedef enum logic [1:0] {
        CMD_CONVERT,
        CMD_ZERO,
        CMD_ERROR
    } cmd_kind_t;

    typedef struct packed {
        cmd_kind_t kind;
        value_t    value;
    } cmd_t;

    // command queue between front and back
    localparam int QUEUE_DEPTH = 2;
    localparam int QUEUE_AW    = $clog2(QUEUE_DEPTH);
    localparam int QUEUE_CNT_W = $clog2(QUEUE_DEPTH + 1);

    typedef struct packed {
        logic full;
        logic empty;
    } queue_status_t;

endpackage

FILE: rtl/itr_operand_if.sv
// input channel carrying the number to convert
interface itr_operand_if import itr_pkg::*; ();
    logic   valid;
    logic   ready;
    value_t value;

    modport source (output valid, output value, input ready);
    modport sink (input valid, input value, output ready);
endinterface

FILE: rtl/itr_numeral_if.sv
// output channel carrying one numeral character per item
interface itr_numeral_if import itr_pkg::*; ();
    logic    valid;
    logic    ready;
    symbol_t symbol;
    logic    last;
    logic    empty_res;
    logic    error;

    modport source (output valid, output symbol, output last, output empty_res,
                    output error, input ready);
    modport sink (input valid, input symbol, input last, input empty_res,
                  input error, output ready);
endinterface

FILE: rtl/itr_front.sv
// front end: accepts operands and classifies them into commands
module itr_front import itr_pkg::*; (
    itr_operand_if.sink operand,
    output logic        push_valid,
    input  logic        push_ready,
    output cmd_t        push_cmd
);

    // handshake passes straight to the queue
    assign push_valid     = operand.valid;
    assign operand.ready  = push_ready;

    // classify: out of range, zero or a real conversion
    always_comb
    begin
        push_cmd.value = operand.value;
        if (operand.value > MAX_VALUE)
        begin
            push_cmd.kind = CMD_ERROR;
        end
        else if (operand.value == '0)
        begin
            push_cmd.kind = CMD_ZERO;
        end
        else
        begin
            push_cmd.kind = CMD_CONVERT;
        end
    end

endmodule

FILE: rtl/itr_queue.sv
// small command queue decoupling front end and back end
module itr_queue import itr_pkg::*; (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          push_valid,
    output logic          push_ready,
    input  cmd_t          push_cmd,
    output logic          pop_valid,
    input  logic          pop_ready,
    output cmd_t          pop_cmd,
    output queue_status_t status
);

    cmd_t                   entry_reg [QUEUE_DEPTH];
    logic [QUEUE_AW-1:0]    wr_ptr_reg, wr_ptr_next;
    logic [QUEUE_AW-1:0]    rd_ptr_reg, rd_ptr_next;
    logic [QUEUE_CNT_W-1:0] count_reg, count_next;
    logic                   do_push;
    logic                   do_pop;

    // occupancy flags
    always_comb
    begin
        status.full  = (count_reg == QUEUE_CNT_W'(QUEUE_DEPTH));
        status.empty = (count_reg == '0);
    end

    assign push_ready = !status.full;
    assign pop_valid  = !status.empty;
    assign pop_cmd    = entry_reg[rd_ptr_reg];
    assign do_push    = push_valid && push_ready;
    assign do_pop     = pop_valid && pop_ready;

    // pointer and count update
    always_comb
    begin
        wr_ptr_next = do_push ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = do_pop ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        count_next  = count_reg + QUEUE_CNT_W'(do_push) - QUEUE_CNT_W'(do_pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // entry storage, no reset needed
    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            entry_reg[wr_ptr_reg] <= push_cmd;
        end
    end

endmodule

FILE: rtl/itr_back.sv
// back end: greedy subtraction, one letter per cycle unless stalled
module itr_back import itr_pkg::*; (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          cmd_valid,
    output logic          cmd_ready,
    input  cmd_t          cmd,
    itr_numeral_if.source numeral
);

    value_t  rem_reg, rem_next;
    pos_t    pos_reg, pos_next;
    logic    pend_reg, pend_next;
    logic    busy_reg, busy_next;
    logic    out_valid_reg, out_valid_next;
    symbol_t symbol_reg, symbol_next;
    logic    last_reg, last_next;
    logic    empty_reg, empty_next;
    logic    error_reg, error_next;

    logic                  adv;
    logic [TABLE_SIZE-1:0] hit;
    pos_t                  hit_pos;
    value_t                rem_diff;
    logic                  has_second;

    // output register may load when empty or being drained
    assign adv       = !out_valid_reg || numeral.ready;
    assign cmd_ready = adv && !busy_reg;

    // parallel compare against every table step not yet passed
    always_comb
    begin
        for (int i = 0; i < TABLE_SIZE; i++)
        begin
            hit[i] = (POS_W'(i) >= pos_reg) && (rem_reg >= STEP_VALUE[i]);
        end
    end

    // lowest matching table position
    always_comb
    begin
        hit_pos = pos_reg;
        for (int i = TABLE_SIZE - 1; i >= 0; i--)
        begin
            if (hit[i])
            begin
                hit_pos = POS_W'(i);
            end
        end
    end

    assign rem_diff   = rem_reg - STEP_VALUE[hit_pos];
    assign has_second = (SECOND_LETTER[hit_pos] != SYM_NONE);

    // next state and next output item
    always_comb
    begin
        rem_next       = rem_reg;
        pos_next       = pos_reg;
        pend_next      = pend_reg;
        busy_next      = busy_reg;
        out_valid_next = out_valid_reg && !numeral.ready;
        symbol_next    = symbol_reg;
        last_next      = last_reg;
        empty_next     = empty_reg;
        error_next     = error_reg;
        if (adv)
        begin
            if (busy_reg)
            begin
                out_valid_next = 1'b1;
                empty_next     = 1'b0;
                error_next     = 1'b0;
                if (pend_reg)
                begin
                    // second letter of a subtractive pair
                    symbol_next = SECOND_LETTER[pos_reg];
                    last_next   = (rem_reg == '0);
                    pend_next   = 1'b0;
                    busy_next   = (rem_reg != '0);
                end
                else
                begin
                    // first letter of the largest fitting step
                    symbol_next = FIRST_LETTER[hit_pos];
                    rem_next    = rem_diff;
                    pos_next    = hit_pos;
                    pend_next   = has_second;
                    last_next   = !has_second && (rem_diff == '0);
                    busy_next   = has_second || (rem_diff != '0);
                end
            end
            else if (cmd_valid)
            begin
                case (cmd.kind)
                    CMD_CONVERT:
                    begin
                        rem_next  = cmd.value;
                        pos_next  = '0;
                        pend_next = 1'b0;
                        busy_next = 1'b1;
                    end
                    CMD_ZERO:
                    begin
                        out_valid_next = 1'b1;
                        symbol_next    = SYM_NONE;
                        last_next      = 1'b1;
                        empty_next     = 1'b1;
                        error_next     = 1'b0;
                    end
                    CMD_ERROR:
                    begin
                        out_valid_next = 1'b1;
                        symbol_next    = SYM_NONE;
                        last_next      = 1'b1;
                        empty_next     = 1'b0;
                        error_next     = 1'b1;
                    end
                    default:
                    begin
                        busy_next = 1'b0;
                    end
                endcase
            end
        end
    end

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rem_reg       <= '0;
            pos_reg       <= '0;
            pend_reg      <= 1'b0;
            busy_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            rem_reg       <= rem_next;
            pos_reg       <= pos_next;
            pend_reg      <= pend_next;
            busy_reg      <= busy_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // output payload
    always_ff @(posedge clk)
    begin
        symbol_reg <= symbol_next;
        last_reg   <= last_next;
        empty_reg  <= empty_next;
        error_reg  <= error_next;
    end

    assign numeral.valid     = out_valid_reg;
    assign numeral.symbol    = symbol_reg;
    assign numeral.last      = last_reg;
    assign numeral.empty_res = empty_reg;
    assign numeral.error     = error_reg;

endmodule

FILE: rtl/integer_to_roman_encoder.sv
// top level of the integer to roman numeral encoder
//
// operand channel takes one 12-bit unsigned number per item; numeral channel
// returns its roman numeral as ascii letters, one letter per item, with last
// set on the final letter. zero gives one item with empty_res set, a number
// above 3999 gives one item with error set; both carry symbol 0 and last.
// the front end classifies each number and places it in a two-entry queue,
// so operands are taken while the back end is still emitting letters.
// an operand passes through the queue entry, then (for a conversion) the
// back-end load, and then into the output register.
// the back end first loads a number and then emits one letter per cycle
// while the receiver is ready; zero and error go out directly as one item.
// the letter rate is set by the single subtract-and-select unit in the back end.
// when the receiver stalls the output register holds, the back end waits and
// the queue fills, after which operand ready drops.
// reset clears the queue, the back end and the output valid at once.
module integer_to_roman_encoder import itr_pkg::*; (
    input  logic          clk,
    input  logic          rst_n,
    itr_operand_if.sink   operand,
    itr_numeral_if.source numeral
);

    logic          push_valid;
    logic          push_ready;
    cmd_t          push_cmd;
    logic          pop_valid;
    logic          pop_ready;
    cmd_t          pop_cmd;
    queue_status_t q_status;

    // classification
    itr_front u_front (
        .operand    (operand),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_cmd   (push_cmd)
    );

    // command queue
    itr_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_cmd   (push_cmd),
        .pop_valid  (pop_valid),
        .pop_ready  (pop_ready),
        .pop_cmd    (pop_cmd),
        .status     (q_status)
    );

    // letter generation
    itr_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd_valid (pop_valid),
        .cmd_ready (pop_ready),
        .cmd       (pop_cmd),
        .numeral   (numeral)
    );

    // queue can never be full and empty together
    assert property (@(posedge clk) disable iff (!rst_n)
        !(q_status.full && q_status.empty))
        else $error("queue reports full and empty");

    // error item is a single marked item with no letter
    assert property (@(posedge clk) disable iff (!rst_n)
        numeral.valid && numeral.error |->
            numeral.last && !numeral.empty_res && (numeral.symbol == SYM_NONE))
        else $error("malformed error item");

    // a letter item always carries a numeral letter
    assert property (@(posedge clk) disable iff (!rst_n)
        numeral.valid && !numeral.error && !numeral.empty_res |->
            (numeral.symbol == LETTER_I) || (numeral.symbol == LETTER_V) ||
            (numeral.symbol == LETTER_X) || (numeral.symbol == LETTER_L) ||
            (numeral.symbol == LETTER_C) || (numeral.symbol == LETTER_D) ||
            (numeral.symbol == LETTER_M))
        else $error("letter item with invalid symbol");

    // an operand above the maximum is queued as an error command
    assert property (@(posedge clk) disable iff (!rst_n)
        operand.valid && operand.ready && (operand.value > MAX_VALUE) |->
            (push_cmd.kind == CMD_ERROR))
        else $error("out of range operand not flagged");

endmodule

FILE: test/integer_to_roman_encoder_tb.sv
// testbench for the integer to roman encoder: directed table, random numbers, numeral check
module integer_to_roman_encoder_tb import itr_pkg::*; ();
    timeunit 1ns;
    timeprecision 1ps;

    localparam int RESET_CYCLES  = 6;
    localparam int RANDOM_ITEMS  = 77;
    localparam int SETTLE_CYCLES = 24;
    localparam int MAX_LETTERS   = 15;
    localparam int STEP_COUNT    = 13;

    // one expected or observed numeral item
    typedef struct packed {
        symbol_t symbol;
        logic    last;
        logic    empty_res;
        logic    error;
    } numeral_t;

    // one row of directed stimulus; typed rows carry their single result
    typedef struct packed {
        value_t   value;
        logic     typed;
        numeral_t res;
    } stim_row_t;

    localparam numeral_t ZERO_RES      = '{SYM_NONE, 1'b1, 1'b1, 1'b0};
    localparam numeral_t RANGE_ERR_RES = '{SYM_NONE, 1'b1, 1'b0, 1'b1};
    localparam numeral_t PREDICTED     = '0;
    localparam int DIRECTED_ROWS = 23;

    logic clk = 1'b0;
    logic rst_n;

    itr_operand_if op_if ();
    itr_numeral_if num_if ();

    integer_to_roman_encoder u_top (
        .clk     (clk),
        .rst_n   (rst_n),
        .operand (op_if),
        .numeral (num_if)
    );

    always #10 clk = ~clk;

    numeral_t expected_letters [$];
    int       mismatches = 0;
    bit       no_gaps    = 1'b0;

    // directed rows: zero, out of range, single letters, pairs, longest and max numerals
    stim_row_t directed_rows [DIRECTED_ROWS] = '{
        '{12'd0,    1'b1, ZERO_RES},
        '{12'd4095, 1'b1, RANGE_ERR_RES},
        '{12'd4000, 1'b1, RANGE_ERR_RES},
        '{12'd1,    1'b1, '{"I", 1'b1, 1'b0, 1'b0}},
        '{12'd5,    1'b1, '{"V", 1'b1, 1'b0, 1'b0}},
        '{12'd10,   1'b1, '{"X", 1'b1, 1'b0, 1'b0}},
        '{12'd50,   1'b1, '{"L", 1'b1, 1'b0, 1'b0}},
        '{12'd100,  1'b1, '{"C", 1'b1, 1'b0, 1'b0}},
        '{12'd500,  1'b1, '{"D", 1'b1, 1'b0, 1'b0}},
        '{12'd1000, 1'b1, '{"M", 1'b1, 1'b0, 1'b0}},
        '{12'd3999, 1'b0, PREDICTED},
        '{12'd3888, 1'b0, PREDICTED},
        '{12'd4,    1'b0, PREDICTED},
        '{12'd9,    1'b0, PREDICTED},
        '{12'd40,   1'b0, PREDICTED},
        '{12'd90,   1'b0, PREDICTED},
        '{12'd400,  1'b0, PREDICTED},
        '{12'd900,  1'b0, PREDICTED},
        '{12'd1994, 1'b0, PREDICTED},
        '{12'd2730, 1'b0, PREDICTED},
        '{12'd1365, 1'b0, PREDICTED},
        '{12'd3000, 1'b0, PREDICTED},
        '{12'd2,    1'b0, PREDICTED}
    };

    // greedy subtraction steps, largest first
    function automatic void roman_step(input int idx, output int unsigned weight,
                                       output symbol_t head, output symbol_t tail);
        tail = SYM_NONE;
        case (idx)
            0:       begin weight = 1000; head = "M"; end
            1:       begin weight = 900;  head = "C"; tail = "M"; end
            2:       begin weight = 500;  head = "D"; end
            3:       begin weight = 400;  head = "C"; tail = "D"; end
            4:       begin weight = 100;  head = "C"; end
            5:       begin weight = 90;   head = "X"; tail = "C"; end
            6:       begin weight = 50;   head = "L"; end
            7:       begin weight = 40;   head = "X"; tail = "L"; end
            8:       begin weight = 10;   head = "X"; end
            9:       begin weight = 9;    head = "I"; tail = "X"; end
            10:      begin weight = 5;    head = "V"; end
            11:      begin weight = 4;    head = "I"; tail = "V"; end
            default: begin weight = 1;    head = "I"; end
        endcase
    endfunction

    // expected numeral letters for one accepted number
    function automatic void predict_numeral(input value_t v);
        int unsigned rem;
        int          pos;
        int          count;
        bit          tail_due;
        bit          have_held;
        numeral_t    held;
        int unsigned weight;
        symbol_t     head;
        symbol_t     tail;
        if (v > MAX_VALUE) begin
            expected_letters.push_back(RANGE_ERR_RES);
            return;
        end
        if (v == '0) begin
            expected_letters.push_back(ZERO_RES);
            return;
        end
        rem       = v;
        pos       = 0;
        count     = 0;
        tail_due  = 1'b0;
        have_held = 1'b0;
        held      = '0;
        tail      = SYM_NONE;
        while (count < MAX_LETTERS) begin
            if (tail_due) begin
                if (have_held)
                    expected_letters.push_back(held);
                held      = '{tail, 1'b0, 1'b0, 1'b0};
                have_held = 1'b1;
                count++;
                tail_due  = 1'b0;
            end else if (rem == 0 || pos >= STEP_COUNT) begin
                break;
            end else begin
                roman_step(pos, weight, head, tail);
                if (rem >= weight) begin
                    if (have_held)
                        expected_letters.push_back(held);
                    held      = '{head, 1'b0, 1'b0, 1'b0};
                    have_held = 1'b1;
                    count++;
                    rem       = rem - weight;
                    tail_due  = (tail != SYM_NONE);
                end else begin
                    pos++;
                end
            end
        end
        // final letter carries last
        if (have_held) begin
            held.last = 1'b1;
            expected_letters.push_back(held);
        end
    endfunction

    // mostly no gap, some short, a few long
    function automatic int idle_cycles();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55)
            return 0;
        else if (r < 90)
            return $urandom_range(1, 3);
        else
            return $urandom_range(8, 30);
    endfunction

    // random numbers weighted toward long numerals, with zero and out of range mixed in
    function automatic value_t random_value();
        int r;
        r = $urandom_range(0, 99);
        if (r < 5)
            return '0;
        else if (r < 13)
            return value_t'($urandom_range(4000, 4095));
        else if (r < 23)
            return value_t'($urandom_range(1, 20));
        else if (r < 35)
            return value_t'($urandom_range(3700, 3999));
        else
            return value_t'($urandom_range(1, 3999));
    endfunction

    // offer one number and record its numeral once it is taken
    task automatic offer_value(input value_t v, input logic typed, input numeral_t res);
        int gap;
        gap = no_gaps ? 0 : idle_cycles();
        if (gap > 0) begin
            op_if.valid <= 1'b0;
            repeat (gap) begin
                op_if.value <= value_t'($urandom_range(0, 4095));
                @(posedge clk);
            end
        end
        op_if.valid <= 1'b1;
        op_if.value <= v;
        do
            @(posedge clk);
        while (op_if.ready !== 1'b1);
        if (typed)
            expected_letters.push_back(res);
        else
            predict_numeral(v);
    endtask

    // compare one received item with the oldest expected letter
    task automatic check_letter();
        numeral_t want;
        if (expected_letters.size() == 0) begin
            $error("unexpected numeral item: symbol %h last %b empty_res %b error %b",
                   num_if.symbol, num_if.last, num_if.empty_res, num_if.error);
            mismatches++;
        end else begin
            want = expected_letters.pop_front();
            if (num_if.symbol !== want.symbol) begin
                $error("symbol: expected %h, got %h", want.symbol, num_if.symbol);
                mismatches++;
            end
            if (num_if.last !== want.last) begin
                $error("last: expected %b, got %b", want.last, num_if.last);
                mismatches++;
            end
            if (num_if.empty_res !== want.empty_res) begin
                $error("empty_res: expected %b, got %b", want.empty_res, num_if.empty_res);
                mismatches++;
            end
            if (num_if.error !== want.error) begin
                $error("error: expected %b, got %b", want.error, num_if.error);
                mismatches++;
            end
        end
    endtask

    // receive side: random stalls, none while no_gaps is set
    initial
    begin
        int stall;
        stall = 0;
        num_if.ready <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (num_if.valid === 1'b1 && num_if.ready === 1'b1)
                check_letter();
            if (stall > 0) begin
                stall--;
                num_if.ready <= 1'b0;
            end else begin
                num_if.ready <= 1'b1;
                if (!no_gaps && $urandom_range(0, 99) < 30)
                    stall = idle_cycles();
            end
        end
    end

    // reset, directed rows, random numbers, drain
    initial
    begin
        int i;
        rst_n       <= 1'b0;
        op_if.valid <= 1'b0;
        op_if.value <= '0;
        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;

        for (i = 0; i < DIRECTED_ROWS; i++)
            offer_value(directed_rows[i].value, directed_rows[i].typed, directed_rows[i].res);

        // every third block of twenty runs back to back on both sides
        for (i = 0; i < RANDOM_ITEMS; i++) begin
            no_gaps = ((i / 20) % 3 == 2);
            offer_value(random_value(), 1'b0, PREDICTED);
        end
        no_gaps = 1'b0;
        op_if.valid <= 1'b0;

        while (expected_letters.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);

        if (mismatches == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

    // hang guard
    initial
    begin
        #10_000_000;
        $display("FAILURE");
        $finish;
    end

endmodule
